FILE: design/idl_pkg.sv
// shared types, constants and helpers of the isometric line rasterizer
package idl_pkg;

  localparam int WIN_WIDTH_DEF  = 1920;
  localparam int WIN_HEIGHT_DEF = 1080;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [33:0] COS30_Q32 = 34'd3719550787;
  localparam logic [11:0] MAX_COUNT = 12'hFFF;

  localparam int PIX_W   = 13;
  localparam int COORD_W = 11;
  localparam int TRANS_W = 12;
  localparam int COLOR_W = 24;
  localparam int OFS_W   = 24;
  localparam int BYTES_W = 32;
  localparam int CNT_W   = 12;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANS_X      = 3'd0,
    REG_TRANS_Y      = 3'd1,
    REG_LINE_STRIDE  = 3'd2,
    REG_BPP          = 3'd3,
    REG_BIG_ENDIAN   = 3'd4,
    REG_FLAT_COLOR   = 3'd5,
    REG_RAISED_COLOR = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PROJ, S_DIFF, S_MAG, S_SQX, S_SQY, S_ROOT, S_DIVX, S_DIVY, S_DONE
  } setup_state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic raised;
  } setup_stat_t;

  typedef struct packed {
    logic [15:0] line_stride;
    logic [2:0]  bpp;
    logic        big_endian;
    logic [23:0] flat_color;
    logic [23:0] raised_color;
  } pix_cfg_t;

  // colour bytes in memory order, unwritten bytes zero
  function automatic logic [31:0] color_bytes(input logic [23:0] color, input logic [2:0] nb,
                                              input logic be);
    logic [31:0] r;
    logic [2:0]  kk;
    logic [5:0]  sh;
    logic [31:0] shifted;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      kk = 3'(k);
      if (kk < nb) begin
        sh = be ? {nb - 3'd1 - kk, 3'b000} : {kk, 3'b000};
        shifted = {8'd0, color} >> sh;
        r[8*k +: 8] = shifted[7:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: design/idl_alu.sv
// shared add / compare-subtract unit of the setup sequencer
module idl_alu #(
  parameter int W = 64
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         lt
);
  logic [W:0] sum;

  assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign res = sum[W-1:0];
  assign lt  = sub & ~sum[W];
endmodule

FILE: design/idl_setup.sv
// segment setup: projection, length square root and step divisions
module idl_setup #(
  parameter int WIN_WIDTH  = idl_pkg::WIN_WIDTH_DEF,
  parameter int WIN_HEIGHT = idl_pkg::WIN_HEIGHT_DEF,
  parameter int FRAC_BITS  = idl_pkg::FRAC_BITS_DEF,
  localparam int CW = FRAC_BITS + 15
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [10:0]       x_start,
  input  logic signed [10:0]       y_start,
  input  logic signed [10:0]       z_start,
  input  logic signed [10:0]       x_end,
  input  logic signed [10:0]       y_end,
  input  logic signed [10:0]       z_end,
  input  logic signed [11:0]       trans_x,
  input  logic signed [11:0]       trans_y,
  output idl_pkg::setup_stat_t     stat,
  output logic signed [CW-1:0]     ax,
  output logic signed [CW-1:0]     ay,
  output logic signed [CW-1:0]     step_x,
  output logic signed [CW-1:0]     step_y,
  output logic [11:0]              count
);
  import idl_pkg::*;

  localparam int MW   = CW - 1;
  localparam int AW   = 2 * MW + 2;
  localparam int LW   = AW - 2 * FRAC_BITS;
  localparam int RW   = LW / 2;
  localparam int CNTW = $clog2(MW + 1);
  localparam logic [33:0] CQ_RAW =
    (COS30_Q32 + (34'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic signed [CW-1:0] CQ = CW'(CQ_RAW);

  setup_state_t state, state_next;

  logic signed [10:0]   xs, ys, zs, xe, ye, ze;
  logic                 raised;
  logic signed [CW-1:0] dxr, dyr;
  logic [AW-1:0]        acc, mcand;
  logic [MW-1:0]        mplier;
  logic [LW-1:0]        src;
  logic [RW:0]          rem;
  logic [RW-1:0]        root;
  logic [11:0]          n;
  logic [11:0]          drem;
  logic [MW-1:0]        dsrc, dq;
  logic [CNTW-1:0]      cnt;

  logic signed [CW-1:0] ox, oy, ax_c, ay_c, dx_c, dy_c, adx, ady;
  logic [MW-1:0]        ux, uy;
  logic [AW-1:0]        alu_a, alu_b, alu_res, sum_next;
  logic                 alu_sub, alu_lt;
  logic [RW-1:0]        root_new;
  logic [11:0]          n_new;
  logic [MW-1:0]        dq_new;
  logic                 last_sq, last_root;

  assign ox   = (CW'(trans_x) + CW'(WIN_WIDTH / 2)) <<< FRAC_BITS;
  assign oy   = (CW'(trans_y) + CW'(WIN_HEIGHT / 2)) <<< FRAC_BITS;
  assign ax_c = CQ * (CW'(xs) - CW'(ys)) + ox;
  assign ay_c = ((CW'(xs) + CW'(ys)) <<< (FRAC_BITS - 1)) - (CW'(zs) <<< FRAC_BITS) + oy;
  assign dx_c = CQ * ((CW'(xe) - CW'(ye)) - (CW'(xs) - CW'(ys)));
  assign dy_c = (((CW'(xe) + CW'(ye)) - (CW'(xs) + CW'(ys))) <<< (FRAC_BITS - 1))
              - ((CW'(ze) - CW'(zs)) <<< FRAC_BITS);
  assign adx  = dxr[CW-1] ? -dxr : dxr;
  assign ady  = dyr[CW-1] ? -dyr : dyr;
  assign ux   = adx[MW-1:0];
  assign uy   = ady[MW-1:0];

  idl_alu #(.W(AW)) u_alu (
    .a(alu_a), .b(alu_b), .sub(alu_sub), .res(alu_res), .lt(alu_lt)
  );

  assign sum_next  = mplier[0] ? alu_res : acc;
  assign root_new  = {root[RW-2:0], ~alu_lt};
  assign n_new     = (root_new > RW'(MAX_COUNT)) ? MAX_COUNT : root_new[11:0];
  assign dq_new    = {dq[MW-2:0], ~alu_lt};
  assign last_sq   = (cnt == CNTW'(MW - 1));
  assign last_root = (cnt == CNTW'(RW - 1));

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    unique case (state)
      S_IDLE: if (start) state_next = S_PROJ;
      S_PROJ: state_next = S_DIFF;
      S_DIFF: state_next = S_MAG;
      S_MAG:  state_next = S_SQX;
      S_SQX, S_SQY: begin
        alu_a = acc;
        alu_b = mcand;
        if (last_sq) state_next = (state == S_SQX) ? S_SQY : S_ROOT;
      end
      S_ROOT: begin
        alu_a   = AW'({rem, src[LW-1:LW-2]});
        alu_b   = AW'({root, 2'b01});
        alu_sub = 1'b1;
        if (last_root) state_next = (n_new == '0) ? S_DONE : S_DIVX;
      end
      S_DIVX, S_DIVY: begin
        alu_a   = AW'({drem, dsrc[MW-1]});
        alu_b   = AW'(n);
        alu_sub = 1'b1;
        if (last_sq) state_next = (state == S_DIVX) ? S_DIVY : S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          xs     <= x_start;
          ys     <= y_start;
          zs     <= z_start;
          xe     <= x_end;
          ye     <= y_end;
          ze     <= z_end;
          raised <= (z_start != '0) || (z_end != '0);
        end
      end
      S_PROJ: begin
        ax <= ax_c;
        ay <= ay_c;
      end
      S_DIFF: begin
        dxr <= dx_c;
        dyr <= dy_c;
      end
      S_MAG: begin
        acc    <= '0;
        mcand  <= AW'(ux);
        mplier <= ux;
        cnt    <= '0;
      end
      S_SQX, S_SQY: begin
        acc    <= sum_next;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (last_sq) begin
          cnt <= '0;
          if (state == S_SQX) begin
            mcand  <= AW'(uy);
            mplier <= uy;
          end else begin
            src  <= sum_next[AW-1:2*FRAC_BITS];
            rem  <= '0;
            root <= '0;
          end
        end
      end
      S_ROOT: begin
        rem  <= alu_lt ? alu_a[RW:0] : alu_res[RW:0];
        root <= root_new;
        src  <= src << 2;
        cnt  <= cnt + 1'b1;
        if (last_root) begin
          n     <= n_new;
          count <= n_new;
          dsrc  <= ux;
          drem  <= '0;
          dq    <= '0;
          cnt   <= '0;
        end
      end
      S_DIVX, S_DIVY: begin
        drem <= alu_lt ? alu_a[11:0] : alu_res[11:0];
        dq   <= dq_new;
        dsrc <= dsrc << 1;
        cnt  <= cnt + 1'b1;
        if (last_sq) begin
          cnt  <= '0;
          drem <= '0;
          dq   <= '0;
          if (state == S_DIVX) begin
            step_x <= dxr[CW-1] ? -CW'(dq_new) : CW'(dq_new);
            dsrc   <= uy;
          end else begin
            step_y <= dyr[CW-1] ? -CW'(dq_new) : CW'(dq_new);
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign stat.busy   = (state != S_IDLE);
  assign stat.done   = (state == S_DONE);
  assign stat.raised = raised;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("start while setup busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> state == S_IDLE) else $error("setup did not return to idle");
endmodule

FILE: design/idl_walk.sv
// dda walker: steps the segment and forms one pixel word per step
module idl_walk #(
  parameter int WIN_WIDTH  = idl_pkg::WIN_WIDTH_DEF,
  parameter int WIN_HEIGHT = idl_pkg::WIN_HEIGHT_DEF,
  parameter int FRAC_BITS  = idl_pkg::FRAC_BITS_DEF,
  localparam int CW = FRAC_BITS + 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 raised,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] step_x_in,
  input  logic signed [CW-1:0] step_y_in,
  input  logic [11:0]          count,
  input  logic                 step_go,
  input  idl_pkg::pix_cfg_t    cfg,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [12:0]   pix_x,
  output logic signed [12:0]   pix_y,
  output logic                 visible,
  output logic [23:0]          byte_offset,
  output logic [31:0]          pixel_bytes,
  output logic                 last
);
  import idl_pkg::*;

  logic signed [CW-1:0] cur_x, cur_y, step_x, step_y;
  logic [11:0]          remaining;
  logic [23:0]          line_color;

  logic signed [12:0] tx, ty;
  logic               vis;
  logic [2:0]         nb;
  logic [27:0]        prod_y;
  logic [14:0]        prod_x;

  function automatic logic signed [12:0] trunc_pix(input logic signed [CW-1:0] v);
    logic [CW-1:0]          mag;
    logic [CW-FRAC_BITS-1:0] p;
    logic signed [12:0]      r;
    mag = v[CW-1] ? CW'(-v) : CW'(v);
    p   = mag[CW-1:FRAC_BITS];
    if (!v[CW-1]) begin
      r = (p > (CW-FRAC_BITS)'(4095)) ? 13'sd4095 : 13'(p);
    end else begin
      r = (p > (CW-FRAC_BITS)'(4096)) ? -13'sd4096 : -(13'(p));
    end
    return r;
  endfunction

  assign tx  = trunc_pix(cur_x);
  assign ty  = trunc_pix(cur_y);
  assign vis = !tx[12] && !ty[12] && (tx < 13'(WIN_WIDTH)) && (ty < 13'(WIN_HEIGHT));
  assign nb  = (cfg.bpp == 3'd0) ? 3'd1 : ((cfg.bpp > 3'd4) ? 3'd4 : cfg.bpp);
  assign prod_y = ty[11:0] * cfg.line_stride;
  assign prod_x = tx[11:0] * nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!load && step_go && remaining != '0) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        cur_x      <= ax;
        cur_y      <= ay;
        step_x     <= step_x_in;
        step_y     <= step_y_in;
        remaining  <= count;
        line_color <= raised ? cfg.raised_color : cfg.flat_color;
      end else if (step_go && remaining != '0) begin
        cur_x       <= cur_x + step_x;
        cur_y       <= cur_y + step_y;
        remaining   <= remaining - 1'b1;
        pix_x       <= tx;
        pix_y       <= ty;
        visible     <= vis;
        byte_offset <= vis ? (prod_y[23:0] + 24'(prod_x)) : '0;
        pixel_bytes <= vis ? color_bytes(line_color, nb, cfg.big_endian) : '0;
        last        <= (remaining == 12'd1);
      end
    end
  end

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    step_go |-> !out_valid || out_ready) else $error("step taken with output slot full");
endmodule

FILE: design/iso_dda_line_rasterizer_unit.sv
// top level of the isometric dda line rasterizer
//
//  channel   direction  word
//  s_axis    in         start (tuser 0) with endpoints, or step (tuser 1)
//  m_axis    out        one pixel per step while a segment is active
//  cfg       in         register index and data, always ready
//
//  a pixel leaves through a one-word output register
//  a start word runs through the setup sequencer: one shared adder does the shift-add squares,
//  the 15-step square root and two restoring divisions (skipped when the length is zero);
//  s_tready is low meanwhile
//  s_tready is also low while a pixel waits in the output register and m_tready is low
//  reset is synchronous, clears control state and sets configuration registers to defaults
module iso_dda_line_rasterizer_unit #(
  parameter int WIN_WIDTH  = idl_pkg::WIN_WIDTH_DEF,
  parameter int WIN_HEIGHT = idl_pkg::WIN_HEIGHT_DEF,
  parameter int FRAC_BITS  = idl_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // x_start, y_start, z_start, x_end, y_end, z_end, zero fill
  input  logic [idl_pkg::IN_DATA_W-1:0]       s_tdata,
  // cmd
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pix_x, pix_y, byte_offset, pixel_bytes, zero fill
  output logic [idl_pkg::OUT_DATA_W-1:0]      m_tdata,
  // visible
  output logic                                m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [idl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [idl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import idl_pkg::*;

  localparam int CW = FRAC_BITS + 15;

  logic signed [11:0] trans_x, trans_y;
  pix_cfg_t           pcfg;
  setup_stat_t        stat;
  logic               accept, start, step_go;
  logic signed [CW-1:0] ax, ay, step_x, step_y;
  logic [11:0]        count;
  logic signed [12:0] pix_x, pix_y;
  logic [23:0]        byte_offset;
  logic [31:0]        pixel_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_x           <= '0;
      trans_y           <= '0;
      pcfg.line_stride  <= 16'd7680;
      pcfg.bpp          <= 3'd4;
      pcfg.big_endian   <= 1'b0;
      pcfg.flat_color   <= 24'hFFFFFF;
      pcfg.raised_color <= 24'hFF0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRANS_X:      trans_x           <= cfg_data[11:0];
        REG_TRANS_Y:      trans_y           <= cfg_data[11:0];
        REG_LINE_STRIDE:  pcfg.line_stride  <= cfg_data[15:0];
        REG_BPP:          pcfg.bpp          <= cfg_data[2:0];
        REG_BIG_ENDIAN:   pcfg.big_endian   <= cfg_data[0];
        REG_FLAT_COLOR:   pcfg.flat_color   <= cfg_data;
        REG_RAISED_COLOR: pcfg.raised_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !stat.busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign start    = accept && !s_tuser;
  assign step_go  = accept && s_tuser;

  idl_setup #(
    .WIN_WIDTH(WIN_WIDTH), .WIN_HEIGHT(WIN_HEIGHT), .FRAC_BITS(FRAC_BITS)
  ) u_setup (
    .clk(clk), .rst(rst), .start(start),
    .x_start(s_tdata[10:0]), .y_start(s_tdata[21:11]), .z_start(s_tdata[32:22]),
    .x_end(s_tdata[43:33]), .y_end(s_tdata[54:44]), .z_end(s_tdata[65:55]),
    .trans_x(trans_x), .trans_y(trans_y),
    .stat(stat), .ax(ax), .ay(ay), .step_x(step_x), .step_y(step_y), .count(count)
  );

  idl_walk #(
    .WIN_WIDTH(WIN_WIDTH), .WIN_HEIGHT(WIN_HEIGHT), .FRAC_BITS(FRAC_BITS)
  ) u_walk (
    .clk(clk), .rst(rst), .load(stat.done), .raised(stat.raised),
    .ax(ax), .ay(ay), .step_x_in(step_x), .step_y_in(step_y), .count(count),
    .step_go(step_go), .cfg(pcfg), .out_ready(m_tready), .out_valid(m_tvalid),
    .pix_x(pix_x), .pix_y(pix_y), .visible(m_tuser), .byte_offset(byte_offset),
    .pixel_bytes(pixel_bytes), .last(m_tlast)
  );

  assign m_tdata = {6'd0, pixel_bytes, byte_offset, pix_y, pix_x};
endmodule
